// ===== rtl/fir_pkg.sv =====
// ----------------------------------------------------------------------------
// fir_pkg: shared types and constants of the radix formatter
// Item structs, divider request/response structs, digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package fir_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int MAX_DIGITS = 64;

	localparam int IN_VALUE_W = 64;
	localparam int BASE_W = 6;
	localparam int CHAR_W = 7;

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int ADDR_W = $clog2(MAX_DIGITS);
	localparam int STEP_W = $clog2(VALUE_WIDTH);

	localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_A = 7'h41;
	localparam logic [CHAR_W-1:0] DEC_MAX = 7'd9;
	localparam logic [CHAR_W-1:0] DEC_COUNT = 7'd10;

	typedef struct packed {
		logic [IN_VALUE_W-1:0] value;
		logic [BASE_W-1:0] base;
	} cmd_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic last_digit;
		logic bad_base;
	} res_item_t;

	typedef struct packed {
		logic start;
		logic [VALUE_WIDTH-1:0] dividend;
		logic [BASE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [VALUE_WIDTH-1:0] quotient;
		logic [BASE_W-1:0] remainder;
	} div_rsp_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [BASE_W-1:0] d);
		logic [CHAR_W-1:0] w;
		w = {1'b0, d};
		if (w <= DEC_MAX) begin
			return CHAR_ZERO + w;
		end
		return CHAR_A + (w - DEC_COUNT);
	endfunction

endpackage

// ===== rtl/format_integer_in_radix.sv =====
// ----------------------------------------------------------------------------
// format_integer_in_radix: unsigned integer to ASCII digits in base 2..36
// Top level: sequencer around a shared serial divider and a remainder store.
// ----------------------------------------------------------------------------
// Each digit costs one pass of the serial divider; emission then reads each
//   digit back (ST_READ) and loads it into the output register (ST_LOAD),
//   waiting while res is stalled. A bad base skips the divider. cmd_stall
//   stays high from accept to the last load.
// Reset: arst_n clears the sequencer, digit count and output valid; the
//   remainder store has no reset and is always written before it is read.
// ----------------------------------------------------------------------------
module format_integer_in_radix (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  fir_pkg::cmd_item_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output fir_pkg::res_item_t res
);
	import fir_pkg::*;

	// Sequencer: wait for an item, divide repeatedly, read digits back, load output.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_LOAD = 2'd3;

	logic [1:0] state_q;
	logic [CNT_W-1:0] n_q;          // digits produced so far
	logic [ADDR_W-1:0] rd_idx_q;    // digit being emitted, counts down to 0
	logic [BASE_W-1:0] base_q;
	logic err_q;
	logic res_valid_q;
	res_item_t res_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic accept;
	logic base_ok;
	logic [CNT_W-1:0] n_next;
	logic div_more;
	logic out_free;
	logic mem_wr_en;
	logic mem_rd_en;
	logic [BASE_W-1:0] mem_rd_data;

	// Take a new item only while idle; a pending result may still wait in res_q.
	assign cmd_stall = (state_q != ST_IDLE);
	assign accept = cmd_valid && !cmd_stall;
	assign base_ok = (cmd.base >= BASE_MIN) && (cmd.base <= BASE_MAX);

	// Keep dividing while the quotient is nonzero and the digit limit is not hit.
	assign n_next = n_q + 1'b1;
	assign div_more = (div_rsp.quotient != '0) && (n_next < CNT_W'(MAX_DIGITS));

	// First pass loads the masked input value; later passes feed back the quotient.
	assign div_req.start = (accept && base_ok) ||
		(state_q == ST_DIV && div_rsp.done && div_more);
	assign div_req.dividend = (state_q == ST_IDLE) ? cmd.value[VALUE_WIDTH-1:0]
		: div_rsp.quotient;
	assign div_req.divisor = (state_q == ST_IDLE) ? cmd.base : base_q;

	// Store each remainder, least significant digit at address 0.
	assign mem_wr_en = (state_q == ST_DIV) && div_rsp.done;
	assign mem_rd_en = (state_q == ST_READ);

	// The output register is free when empty or when its item leaves this cycle.
	assign out_free = !res_valid_q || !res_stall;

	fir_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	fir_digit_ram u_digit_ram (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (n_q[ADDR_W-1:0]),
		.wr_data (div_rsp.remainder),
		.rd_en   (mem_rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (mem_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q <= '0;
			rd_idx_q <= '0;
			base_q <= '0;
			err_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// Raise the output valid on a load; drop it once the item has been taken.
			if (state_q == ST_LOAD && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						base_q <= cmd.base;
						n_q <= '0;
						err_q <= !base_ok;
						state_q <= base_ok ? ST_DIV : ST_LOAD;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						n_q <= n_next;
						if (!div_more) begin
							// Most significant digit sits at the last written address.
							rd_idx_q <= n_q[ADDR_W-1:0];
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						if (err_q || rd_idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q - 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output payload: bad base gives one flagged item with no digit.
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && out_free) begin
			if (err_q) begin
				res_q.digit_char <= '0;
				res_q.last_digit <= 1'b1;
				res_q.bad_base <= 1'b1;
			end else begin
				res_q.digit_char <= digit_to_ascii(mem_rd_data);
				res_q.last_digit <= (rd_idx_q == '0);
				res_q.bad_base <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	// A flagged item is always the whole run and carries no character.
	a_bad_base_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.bad_base |-> res.last_digit && res.digit_char == '0)
		else $error("bad_base item without last_digit or with a character");

	// A digit character is always a decimal digit or an upper-case letter.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.bad_base |->
			(res.digit_char >= CHAR_ZERO && res.digit_char <= CHAR_ZERO + DEC_MAX) ||
			(res.digit_char >= CHAR_A && res.digit_char <= 7'h5A))
		else $error("digit character out of range");

	// The digit count never passes the store depth.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(MAX_DIGITS))
		else $error("digit count beyond MAX_DIGITS");

	// The divider start request is never raised back to back.
	a_div_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> !div_req.start)
		else $error("divider restarted during a pass");

endmodule

// ===== rtl/fir_divider.sv =====
// ----------------------------------------------------------------------------
// fir_divider: serial restoring divider
// Divides a VALUE_WIDTH-bit dividend by a small radix, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module fir_divider (
	input  logic clk,
	input  logic arst_n,
	input  fir_pkg::div_req_t req,
	output fir_pkg::div_rsp_t rsp
);
	import fir_pkg::*;

	logic busy_q;
	logic done_q;
	logic [STEP_W-1:0] step_q;
	logic [VALUE_WIDTH-1:0] dq_q;
	logic [BASE_W-1:0] rem_q;
	logic [BASE_W-1:0] divisor_q;

	logic [BASE_W:0] trial;
	logic [BASE_W:0] diff;
	logic fits;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	assign trial = {rem_q, dq_q[VALUE_WIDTH-1]};
	assign diff = trial - {1'b0, divisor_q};
	assign fits = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (req.start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				step_q <= STEP_W'(VALUE_WIDTH - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
					step_q <= step_q - 1'b1;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q <= req.dividend;
			rem_q <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			dq_q <= {dq_q[VALUE_WIDTH-2:0], fits};
			rem_q <= fits ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = dq_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== rtl/fir_digit_ram.sv =====
// ----------------------------------------------------------------------------
// fir_digit_ram: remainder store
// One write port, one registered read port, MAX_DIGITS entries.
// ----------------------------------------------------------------------------
module fir_digit_ram (
	input  logic clk,
	input  logic wr_en,
	input  logic [fir_pkg::ADDR_W-1:0] wr_addr,
	input  logic [fir_pkg::BASE_W-1:0] wr_data,
	input  logic rd_en,
	input  logic [fir_pkg::ADDR_W-1:0] rd_addr,
	output logic [fir_pkg::BASE_W-1:0] rd_data
);
	import fir_pkg::*;

	logic [BASE_W-1:0] mem_q [MAX_DIGITS];
	logic [BASE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== tb/tb_format_integer_in_radix.sv =====
// ----------------------------------------------------------------------------
// tb_format_integer_in_radix: self-checking bench of the radix formatter
// Sends value/base items over the cmd channel and checks every digit item on
// the res channel against a typed-in item or an in-bench model of repeated
// division. Runs a directed table (zeros, full-width values, base edges, bad
// bases), then random items, with random idling and stalling on both channels.
// ----------------------------------------------------------------------------
module tb_format_integer_in_radix;
	timeunit 1ns;
	timeprecision 1ps;

	import fir_pkg::*;

	// Directed row: the expected item is typed in only for rows giving one item.
	typedef struct {
		logic [IN_VALUE_W-1:0] value;
		logic [BASE_W-1:0] base;
		bit typed;
		res_item_t want;
	} probe_t;

	localparam int PROBE_COUNT = 21;
	localparam int RANDOM_ITEMS = 120;
	localparam int IDLE_PCT = 26;
	localparam int TAIL_CYCLES = 150;
	localparam logic [IN_VALUE_W-1:0] ALL_ONES = '1;
	localparam res_item_t BAD_BASE_ITEM = '{7'd0, 1'b1, 1'b1};

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_item_t cmd;
	logic res_valid;
	logic res_stall;
	res_item_t res;

	// Digits still owed by the block, oldest first.
	res_item_t due_digits[$];

	// Quiet stretch: neither side idles while it is set.
	bit calm;
	int error_count;
	int items_sent;
	int bad_sent;
	int digits_seen;

	probe_t probes [0:PROBE_COUNT-1] = '{
		'{64'd0, 6'd10, 1'b1, '{7'h30, 1'b1, 1'b0}},
		'{64'd0, 6'd2, 1'b1, '{7'h30, 1'b1, 1'b0}},
		'{64'd0, 6'd36, 1'b1, '{7'h30, 1'b1, 1'b0}},
		'{64'd1, 6'd2, 1'b1, '{7'h31, 1'b1, 1'b0}},
		'{64'd9, 6'd10, 1'b1, '{7'h39, 1'b1, 1'b0}},
		'{64'd10, 6'd11, 1'b1, '{7'h41, 1'b1, 1'b0}},
		'{64'd35, 6'd36, 1'b1, '{7'h5A, 1'b1, 1'b0}},
		'{ALL_ONES, 6'd2, 1'b0, '0},
		'{ALL_ONES, 6'd16, 1'b0, '0},
		'{ALL_ONES, 6'd36, 1'b0, '0},
		'{ALL_ONES, 6'd10, 1'b0, '0},
		'{64'd36, 6'd36, 1'b0, '0},
		'{64'd1295, 6'd36, 1'b0, '0},
		'{64'h8000_0000_0000_0000, 6'd2, 1'b0, '0},
		'{64'h0123_4567_89AB_CDEF, 6'd16, 1'b0, '0},
		'{64'd12345, 6'd0, 1'b1, BAD_BASE_ITEM},
		'{64'd12345, 6'd1, 1'b1, BAD_BASE_ITEM},
		'{64'd12345, 6'd37, 1'b1, BAD_BASE_ITEM},
		'{ALL_ONES, 6'd63, 1'b1, BAD_BASE_ITEM},
		'{64'd0, 6'd0, 1'b1, BAD_BASE_ITEM},
		'{64'h5555_AAAA_5555_AAAA, 6'd3, 1'b0, '0}
	};

	format_integer_in_radix uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Queue the flagged item for a bad base; else divide the value down by the base
	// and queue the remainders as ASCII digits, most significant first, last marked.
	function automatic void spell_in_radix(input cmd_item_t c);
		logic [IN_VALUE_W-1:0] quot;
		logic [IN_VALUE_W-1:0] radix;
		logic [BASE_W-1:0] rems [0:MAX_DIGITS-1];
		logic [CHAR_W-1:0] d;
		res_item_t r;
		int n;
		radix = IN_VALUE_W'(c.base);
		if (c.base < BASE_MIN || c.base > BASE_MAX) begin
			due_digits.push_back(BAD_BASE_ITEM);
			return;
		end
		// Ignore value bits above the formatter's width.
		quot = c.value & (ALL_ONES >> (IN_VALUE_W - VALUE_WIDTH));
		n = 0;
		forever begin
			rems[n] = BASE_W'(quot % radix);
			n++;
			if (quot < radix || n >= MAX_DIGITS) begin
				break;
			end
			quot = quot / radix;
		end
		for (int k = n - 1; k >= 0; k--) begin
			d = {1'b0, rems[k]};
			r.digit_char = (d <= 7'd9) ? CHAR_ZERO + d : CHAR_A + (d - 7'd10);
			r.last_digit = (k == 0);
			r.bad_base = 1'b0;
			due_digits.push_back(r);
		end
	endfunction

	// Present one item at a falling edge, hold it until accepted, then queue
	// what it must produce. Returns at the next falling edge.
	task automatic send_cmd(input cmd_item_t c, input bit typed, input res_item_t want);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			cmd_valid = 1'b0;
			@(negedge clk);
		end
		cmd_valid = 1'b1;
		cmd = c;
		do begin
			@(posedge clk);
		end while (cmd_stall);
		if (typed) begin
			due_digits.push_back(want);
		end else begin
			spell_in_radix(c);
		end
		items_sent++;
		if (c.base < BASE_MIN || c.base > BASE_MAX) begin
			bad_sent++;
		end
		@(negedge clk);
	endtask

	// Random item: mostly good bases with values of random bit length, a few
	// full-range extremes, and about one bad base in ten.
	function automatic cmd_item_t random_cmd();
		cmd_item_t c;
		int bits;
		bits = $urandom_range(1, IN_VALUE_W);
		c.value = {$urandom, $urandom};
		c.value = c.value & (ALL_ONES >> (IN_VALUE_W - bits));
		if ($urandom_range(15) == 0) begin
			c.value = $urandom_range(1) ? ALL_ONES : '0;
		end
		if ($urandom_range(9) == 0) begin
			c.base = $urandom_range(1) ? BASE_W'($urandom_range(1)) :
				BASE_W'($urandom_range(37, 63));
		end else begin
			c.base = BASE_W'($urandom_range(2, 36));
		end
		return c;
	endfunction

	// Receiver: stall at random, except in the quiet stretch.
	always @(negedge clk) begin
		res_stall = calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
	end

	// Check each accepted digit against the oldest one owed.
	always @(posedge clk) begin
		res_item_t exp_item;
		if (arst_n && res_valid && !res_stall) begin
			digits_seen++;
			if (due_digits.size() == 0) begin
				$display("%0t: unexpected digit item %h", $time, res);
				error_count++;
			end else begin
				exp_item = due_digits.pop_front();
				if (res.digit_char !== exp_item.digit_char) begin
					$display("%0t: digit_char expected %h actual %h", $time,
						exp_item.digit_char, res.digit_char);
					error_count++;
				end
				if (res.last_digit !== exp_item.last_digit) begin
					$display("%0t: last_digit expected %b actual %b", $time,
						exp_item.last_digit, res.last_digit);
					error_count++;
				end
				if (res.bad_base !== exp_item.bad_base) begin
					$display("%0t: bad_base expected %b actual %b", $time,
						exp_item.bad_base, res.bad_base);
					error_count++;
				end
			end
		end
	end

	initial begin
		clk = 0;
		arst_n = 0;
		cmd_valid = 0;
		cmd = '0;
		res_stall = 0;
		calm = 0;
		error_count = 0;
		items_sent = 0;
		bad_sent = 0;
		digits_seen = 0;

		// Hold reset, then release it at a falling edge.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the directed table.
		for (int i = 0; i < PROBE_COUNT; i++) begin
			send_cmd('{probes[i].value, probes[i].base}, probes[i].typed, probes[i].want);
		end

		// Random items; a quiet stretch in the middle, and once drain fully
		// before sending on.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= 40 && i < 70);
			if (i == 90) begin
				cmd_valid = 1'b0;
				while (due_digits.size() != 0) begin
					@(negedge clk);
				end
			end
			send_cmd(random_cmd(), 1'b0, '0);
		end
		cmd_valid = 1'b0;
		calm = 0;

		// Drain, then give any stray digit time to show up.
		while (due_digits.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d items (%0d with a bad base), checked %0d digit items.",
			items_sent, bad_sent, digits_seen);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", error_count);
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#50_000_000;
		$display("Timed out with %0d digit items still owed", due_digits.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
